// ===== src/tpe_pkg.sv =====
// Shared types and codes for the timer pool expiry engine.
`default_nettype none

package tpe_pkg;

  // Default slot count and time word width
  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned TIME_W        = 64;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ADDED          = 3'd0,
    KIND_FULL           = 3'd1,
    KIND_CANCEL_FOUND   = 3'd2,
    KIND_CANCEL_UNKNOWN = 3'd3,
    KIND_FIRED          = 3'd4,
    KIND_DONE           = 3'd5
  } kind_e;

  // Input beat
  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] expire_time;
    logic              repeat_req;
    logic [TIME_W-1:0] period;
    logic [3:0]        timer_id;
    logic [TIME_W-1:0] now_time;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot_id;
    logic       last;
  } out_beat_t;

  // Result handoff from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  function automatic out_beat_t mk_res(kind_e k, logic [3:0] s, logic l);
    out_beat_t r;
    r.kind    = k;
    r.slot_id = s;
    r.last    = l;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/tpe_ram.sv =====
// Single write, single read port slot memory with registered read data.
`default_nettype none

module tpe_ram
  import tpe_pkg::*;
#(
  parameter  int unsigned DEPTH = NUM_SLOTS_DEF,
  parameter  int unsigned WIDTH = TIME_W,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/tpe_ctrl.sv =====
// Command sequencer: slot flags, expiry/period memories, shared compare unit.
`default_nettype none

module tpe_ctrl
  import tpe_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_beat_i,
  output res_t          res_o,
  input  wire logic     res_ready_i
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_CANCEL = 3'd2;
  localparam logic [2:0] ST_PEND   = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]           state_q, state_d, ret_q, ret_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IW-1:0]        rd_idx_q;
  logic [NUM_SLOTS-1:0] used_q, used_d, armed_q, armed_d, pending_q, pending_d;
  logic                 best_vld_q, best_vld_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [TIME_W-1:0]    best_q, best_d;
  out_beat_t            res_q, res_d;

  // Latched command payload; time_q holds expire_time for add, now_time for tick
  logic [TIME_W-1:0]    time_q, per_in_q;
  logic                 rep_in_q;
  logic [3:0]           id_q;

  logic [IW-1:0]        cnt_idx, id_idx;
  logic                 cnt_last, found;

  // Memory ports
  logic                 exp_we, per_we;
  logic [IW-1:0]        exp_waddr;
  logic [TIME_W-1:0]    exp_wdata, exp_rdata;
  logic [TIME_W:0]      per_rdata;

  // Shared compare unit and reload adder
  logic [TIME_W-1:0]    cmp_a, cmp_b, sum;
  logic                 cmp_lt;

  assign cnt_idx  = cnt_q[IW-1:0];
  assign cnt_last = (cnt_q == CW'(NUM_SLOTS));
  assign id_idx   = IW'(id_q);
  assign found    = (32'(id_q) < NUM_SLOTS) && used_q[id_idx];
  assign sum      = time_q + per_rdata[TIME_W-1:0];

  assign cmp_a  = (state_q == ST_PEND) ? time_q : exp_rdata;
  assign cmp_b  = (state_q == ST_PEND) ? exp_rdata : best_q;
  assign cmp_lt = (cmp_a < cmp_b);

  assign in_ready_o = (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_EMIT);
  assign res_o.beat  = res_q;

  tpe_ram #(.DEPTH(NUM_SLOTS), .WIDTH(TIME_W)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .raddr_i (cnt_idx),
    .rdata_o (exp_rdata)
  );

  // Period memory carries the repeat flag in its top bit
  tpe_ram #(.DEPTH(NUM_SLOTS), .WIDTH(TIME_W + 1)) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (cnt_idx),
    .wdata_i ({rep_in_q, per_in_q}),
    .raddr_i (best_idx_q),
    .rdata_o (per_rdata)
  );

  // Next-state and datapath control
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    used_d     = used_q;
    armed_d    = armed_q;
    pending_d  = pending_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    res_d      = res_q;
    exp_we     = 1'b0;
    per_we     = 1'b0;
    exp_waddr  = cnt_idx;
    exp_wdata  = time_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          unique case (in_beat_i.command)
            CMD_ADD:    state_d = ST_ADD;
            CMD_CANCEL: state_d = ST_CANCEL;
            CMD_TICK:   state_d = ST_PEND;
            default:    state_d = ST_IDLE;
          endcase
        end
      end

      // Walk up from slot 0 looking for the first free slot
      ST_ADD: begin
        if (cnt_last) begin
          res_d   = mk_res(KIND_FULL, 4'd0, 1'b1);
          ret_d   = ST_IDLE;
          state_d = ST_EMIT;
        end else if (!used_q[cnt_idx]) begin
          exp_we           = 1'b1;
          per_we           = 1'b1;
          used_d[cnt_idx]  = 1'b1;
          armed_d[cnt_idx] = 1'b1;
          res_d            = mk_res(KIND_ADDED, 4'(cnt_idx), 1'b1);
          ret_d            = ST_IDLE;
          state_d          = ST_EMIT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      ST_CANCEL: begin
        if (found) begin
          armed_d[id_idx] = 1'b0;
        end
        res_d   = mk_res(found ? KIND_CANCEL_FOUND : KIND_CANCEL_UNKNOWN, id_q, 1'b1);
        ret_d   = ST_IDLE;
        state_d = ST_EMIT;
      end

      // Snapshot of expired slots: one memory read per cycle
      ST_PEND: begin
        if (!cnt_last) begin
          cnt_d    = cnt_q + CW'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          pending_d[rd_idx_q] = used_q[rd_idx_q] & ~cmp_lt;
        end
        if (cnt_last && !rd_vld_q) begin
          cnt_d      = '0;
          best_vld_d = 1'b0;
          state_d    = ST_ROUND;
        end
      end

      // One pass for the earliest pending slot; strict less keeps lowest slot on ties
      ST_ROUND: begin
        if (!cnt_last) begin
          cnt_d    = cnt_q + CW'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && pending_q[rd_idx_q] && (!best_vld_q || cmp_lt)) begin
          best_vld_d = 1'b1;
          best_d     = exp_rdata;
          best_idx_d = rd_idx_q;
        end
        if (cnt_last && !rd_vld_q) begin
          if (best_vld_q) begin
            state_d = ST_UPDATE;
          end else begin
            res_d   = mk_res(KIND_DONE, 4'd0, 1'b1);
            ret_d   = ST_IDLE;
            state_d = ST_EMIT;
          end
        end
      end

      // Handle the chosen slot: fire, reload or free
      ST_UPDATE: begin
        pending_d[best_idx_q] = 1'b0;
        if (armed_q[best_idx_q] && per_rdata[TIME_W]) begin
          exp_we    = 1'b1;
          exp_waddr = best_idx_q;
          exp_wdata = sum;
        end else begin
          used_d[best_idx_q]  = 1'b0;
          armed_d[best_idx_q] = 1'b0;
        end
        cnt_d      = '0;
        best_vld_d = 1'b0;
        if (armed_q[best_idx_q]) begin
          res_d   = mk_res(KIND_FIRED, 4'(best_idx_q), 1'b0);
          ret_d   = ST_ROUND;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ROUND;
        end
      end

      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ret_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ret_q      <= ST_IDLE;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      used_q     <= '0;
      armed_q    <= '0;
      pending_q  <= '0;
      best_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      used_q     <= used_d;
      armed_q    <= armed_d;
      pending_q  <= pending_d;
      best_vld_q <= best_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= cnt_idx;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    res_q      <= res_d;
    if (in_valid_i && in_ready_o) begin
      time_q   <= (in_beat_i.command == CMD_TICK) ? in_beat_i.now_time
                                                  : in_beat_i.expire_time;
      per_in_q <= in_beat_i.period;
      rep_in_q <= in_beat_i.repeat_req;
      id_q     <= in_beat_i.timer_id;
    end
  end

  // An armed slot is always in use
  a_armed_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & ~used_q) == '0)
    else $error("armed slot not in use");

  // Pending set stays within used slots
  a_pending_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & ~used_q) == '0)
    else $error("pending slot not in use");

  // No leftover pending slots once a command is finished
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pending_q == '0))
    else $error("pending slots left at idle");

  // The closing beat of a command returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_ready_i && res_q.last) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after closing beat");

endmodule

`default_nettype wire

// ===== src/timer_pool_expiry_engine.sv =====
// Timer pool expiry engine top level: command sequencer and output register.
//
// A pool of NUM_SLOTS timer slots driven by one command per input beat. Add
// takes the lowest free slot, one slot checked per cycle; add and cancel each
// then hand one result beat to the output register. A tick first reads every
// stored expiry once and then runs one full pass per expired slot plus a
// final empty pass, handing over a fire beat for each armed slot it handles.
// The single read port of the expiry memory yields one slot per cycle. The
// block takes no new command until every result beat of the current one has
// been handed to the output register; that register lets the last beat wait
// for the consumer while the next command is taken. Ties in expiry are handled
// lowest slot first; slot ids on the output are the low four bits of the slot.
`default_nettype none

module timer_pool_expiry_engine
  import tpe_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_beat_o
);

  res_t      res;
  logic      res_ready;
  logic      out_valid_q;
  out_beat_t out_q;

  tpe_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register takes a beat whenever it is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/tb_timer_pool_expiry_engine.sv =====
// Testbench for the timer pool expiry engine: directed table, random commands, beat checker.

module tb_timer_pool_expiry_engine;
  import tpe_pkg::*;

  localparam int unsigned NS          = NUM_SLOTS_DEF;
  localparam logic [1:0]  CMD_IGNORED = 2'd3;
  localparam logic [63:0] T_MAX       = '1;
  localparam int          RAND_ITEMS  = 262;
  localparam int          STUCK_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 400;

  // Directed stimulus row; when known is set the result is typed in by hand
  typedef struct packed {
    in_beat_t   beat;
    logic       known;
    kind_e      kind;
    logic [3:0] slot;
  } dir_row_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  // Shadow timer table
  logic [NS-1:0] tmr_used  = '0;
  logic [NS-1:0] tmr_armed = '0;
  logic [NS-1:0] tmr_rep   = '0;
  logic [63:0]   tmr_due[NS];
  logic [63:0]   tmr_per[NS];

  out_beat_t   pending_events[$];
  dir_row_t    dir_rows[17];
  logic [63:0] clock_us    = 64'd1000;
  bit          idle_en     = 1'b1;
  bit          sending     = 1'b0;
  int          stall_left  = 0;
  int          stuck_cycles = 0;
  int          bad_beats   = 0;

  timer_pool_expiry_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Append one expected beat at the tail of the queue
  function automatic void queue_beat(input out_beat_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  // Update the shadow table for one command and queue the beats it produces
  function automatic void apply_timer_cmd(input in_beat_t b);
    logic [NS-1:0] hit;
    int            pick;
    bit            placed;
    placed = 1'b0;
    case (b.command)
      CMD_ADD: begin
        for (int i = 0; i < NS; i++) begin
          if (!placed && !tmr_used[i]) begin
            placed       = 1'b1;
            tmr_used[i]  = 1'b1;
            tmr_armed[i] = 1'b1;
            tmr_rep[i]   = b.repeat_req;
            tmr_due[i]   = b.expire_time;
            tmr_per[i]   = b.period;
            queue_beat(out_beat_t'{KIND_ADDED, 4'(i), 1'b1});
          end
        end
        if (!placed) queue_beat(out_beat_t'{KIND_FULL, 4'd0, 1'b1});
      end
      CMD_CANCEL: begin
        if (tmr_used[b.timer_id]) begin
          tmr_armed[b.timer_id] = 1'b0;
          queue_beat(out_beat_t'{KIND_CANCEL_FOUND, b.timer_id, 1'b1});
        end else begin
          queue_beat(out_beat_t'{KIND_CANCEL_UNKNOWN, b.timer_id, 1'b1});
        end
      end
      CMD_TICK: begin
        // expired set is frozen at the start of the tick
        for (int i = 0; i < NS; i++) hit[i] = tmr_used[i] && (b.now_time >= tmr_due[i]);
        while (hit != '0) begin
          pick = -1;
          for (int i = 0; i < NS; i++) begin
            if (hit[i] && (pick < 0 || tmr_due[i] < tmr_due[pick])) pick = i;
          end
          hit[pick] = 1'b0;
          if (tmr_armed[pick]) queue_beat(out_beat_t'{KIND_FIRED, 4'(pick), 1'b0});
          if (tmr_armed[pick] && tmr_rep[pick]) begin
            tmr_due[pick] = b.now_time + tmr_per[pick];
          end else begin
            tmr_used[pick]  = 1'b0;
            tmr_armed[pick] = 1'b0;
          end
        end
        queue_beat(out_beat_t'{KIND_DONE, 4'd0, 1'b1});
      end
      default: begin
      end
    endcase
  endfunction

  // Random command around a slowly advancing time base
  function automatic in_beat_t make_random_cmd();
    in_beat_t b;
    int       roll;
    b.command     = CMD_ADD;
    b.expire_time = {$urandom(), $urandom()};
    b.repeat_req  = 1'($urandom_range(0, 1));
    b.period      = {$urandom(), $urandom()};
    b.timer_id    = 4'($urandom_range(0, 15));
    b.now_time    = {$urandom(), $urandom()};
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      if ($urandom_range(0, 9) != 0) b.expire_time = clock_us + $urandom_range(0, 300);
      if ($urandom_range(0, 9) != 0) b.period = 64'($urandom_range(0, 200));
    end else if (roll < 60) begin
      b.command = CMD_CANCEL;
      // mostly aim at a live slot
      if (tmr_used != '0 && $urandom_range(0, 4) != 0) begin
        while (!tmr_used[b.timer_id]) b.timer_id = b.timer_id + 4'd1;
      end
    end else if (roll < 96) begin
      b.command = CMD_TICK;
      case ($urandom_range(0, 19))
        0: b.now_time = T_MAX;
        1: begin
        end
        default: begin
          clock_us   = clock_us + $urandom_range(0, 120);
          b.now_time = clock_us;
        end
      endcase
    end else begin
      b.command = CMD_IGNORED;
    end
    return b;
  endfunction

  // Present one command beat; entered and left at a rising edge
  task automatic issue_cmd(input in_beat_t b);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    apply_timer_cmd(b);
  endtask

  // Drop valid and let every outstanding result drain; always leaves on a later edge
  task automatic hold_until_quiet();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
  endtask

  // Result side backpressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0 && idle_en) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    end
  end

  // Compare each result beat with the oldest queued one
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_events.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected beat: kind %0d slot %0d last %0d",
                   out_beat_o.kind, out_beat_o.slot_id, out_beat_o.last);
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== out_beat_o.kind || want.slot_id !== out_beat_o.slot_id ||
            want.last !== out_beat_o.last) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("mismatch: want kind %0d slot %0d last %0d, got kind %0d slot %0d last %0d",
                     want.kind, want.slot_id, want.last,
                     out_beat_o.kind, out_beat_o.slot_id, out_beat_o.last);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat while work is outstanding
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stuck_cycles <= 0;
    end else if (sending || pending_events.size() != 0) begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_timer_pool_expiry_engine NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_beat_t b;
    for (int i = 0; i < NS; i++) begin
      tmr_due[i] = '0;
      tmr_per[i] = '0;
    end

    // Directed rows: empty table, extremes, expiry ties, cancel twice, wrap on reload
    dir_rows[0]  = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, 64'd0}, 1'b1, KIND_DONE, 4'd0};
    dir_rows[1]  = '{'{CMD_CANCEL, 64'd0, 1'b0, 64'd0, 4'd0, 64'd0}, 1'b1,
                     KIND_CANCEL_UNKNOWN, 4'd0};
    dir_rows[2]  = '{'{CMD_CANCEL, 64'd0, 1'b0, 64'd0, 4'd15, 64'd0}, 1'b1,
                     KIND_CANCEL_UNKNOWN, 4'd15};
    dir_rows[3]  = '{'{CMD_ADD, 64'd0, 1'b0, 64'd0, 4'd0, 64'd0}, 1'b1, KIND_ADDED, 4'd0};
    dir_rows[4]  = '{'{CMD_ADD, T_MAX, 1'b1, T_MAX, 4'd0, 64'd0}, 1'b1, KIND_ADDED, 4'd1};
    dir_rows[5]  = '{'{CMD_ADD, 64'd100, 1'b1, 64'd50, 4'd0, 64'd0}, 1'b1, KIND_ADDED, 4'd2};
    dir_rows[6]  = '{'{CMD_ADD, 64'd100, 1'b0, 64'd0, 4'd0, 64'd0}, 1'b1, KIND_ADDED, 4'd3};
    dir_rows[7]  = '{'{CMD_CANCEL, 64'd0, 1'b0, 64'd0, 4'd3, 64'd0}, 1'b1,
                     KIND_CANCEL_FOUND, 4'd3};
    dir_rows[8]  = '{'{CMD_CANCEL, 64'd0, 1'b0, 64'd0, 4'd3, 64'd0}, 1'b1,
                     KIND_CANCEL_FOUND, 4'd3};
    dir_rows[9]  = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, 64'd99}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[10] = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, 64'd100}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[11] = '{'{CMD_ADD, 64'd5, 1'b1, 64'd0, 4'd0, 64'd0}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[12] = '{'{CMD_IGNORED, T_MAX, 1'b1, T_MAX, 4'd15, T_MAX}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[13] = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, 64'd200}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[14] = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, T_MAX}, 1'b0, KIND_ADDED, 4'd0};
    dir_rows[15] = '{'{CMD_CANCEL, 64'd0, 1'b0, 64'd0, 4'd1, 64'd0}, 1'b1,
                     KIND_CANCEL_FOUND, 4'd1};
    dir_rows[16] = '{'{CMD_TICK, 64'd0, 1'b0, 64'd0, 4'd0, T_MAX}, 1'b0, KIND_ADDED, 4'd0};

    repeat (9) @(posedge clk_i);
    rst_ni  <= 1'b1;
    sending = 1'b1;

    // Directed part; hand-typed rows replace the shadow table's single beat
    for (int r = 0; r < 17; r++) begin
      issue_cmd(dir_rows[r].beat);
      if (dir_rows[r].known) begin
        void'(pending_events.pop_back());
        queue_beat(out_beat_t'{dir_rows[r].kind, dir_rows[r].slot, 1'b1});
      end
    end
    hold_until_quiet();

    // Random part: fill the table, fire everything, then mixed traffic
    for (int k = 0; k < RAND_ITEMS; k++) begin
      idle_en = (k % 60) < 45 && k < RAND_ITEMS - 40;
      b = make_random_cmd();
      if (k < 17) begin
        b.command     = CMD_ADD;
        b.expire_time = clock_us + $urandom_range(0, 300);
      end else if (k == 17) begin
        b.command  = CMD_TICK;
        b.now_time = T_MAX;
      end
      issue_cmd(b);
      if (k == 130) hold_until_quiet();
    end
    in_valid <= 1'b0;
    sending  = 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (bad_beats == 0) begin
      $display("tb_timer_pool_expiry_engine OK");
    end else begin
      $display("tb_timer_pool_expiry_engine NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tpe_pkg.sv
src/tpe_ram.sv
src/tpe_ctrl.sv
src/timer_pool_expiry_engine.sv
tb/tb_timer_pool_expiry_engine.sv
